@@ rtl/pf_pkg.sv @@
// Package with the shared types, constants and key-square lookup functions of the Playfair block.
`default_nettype none

package pf_pkg;

  localparam int GRID_SIDE   = 5;
  localparam int LETTER_W    = 5;
  localparam int ROW_W       = GRID_SIDE * LETTER_W;
  localparam int POS_W       = $clog2(GRID_SIDE);
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [LETTER_W-1:0]                letter_t;
  typedef logic [POS_W-1:0]                   pos_t;
  typedef logic [GRID_SIDE-1:0][ROW_W-1:0]    square_t;
  typedef logic [CFG_IDX_W-1:0]               cfg_idx_t;

  // Letter codes.
  localparam letter_t CODE_I = 5'd8;
  localparam letter_t CODE_J = 5'd9;
  localparam letter_t CODE_Q = 5'd16;
  localparam letter_t CODE_X = 5'd23;
  localparam letter_t CODE_Z = 5'd25;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_ROW0 = 3'd0;
  localparam cfg_idx_t CFG_ROW1 = 3'd1;
  localparam cfg_idx_t CFG_ROW2 = 3'd2;
  localparam cfg_idx_t CFG_ROW3 = 3'd3;
  localparam cfg_idx_t CFG_ROW4 = 3'd4;
  localparam cfg_idx_t CFG_MODE = 3'd5;

  // Reset square: the plain alphabet without J, row by row.
  localparam logic [ROW_W-1:0] ROW0_RST = 25'd4294688;
  localparam logic [ROW_W-1:0] ROW1_RST = 25'd10755269;
  localparam logic [ROW_W-1:0] ROW2_RST = 25'd16201099;
  localparam logic [ROW_W-1:0] ROW3_RST = 25'd21613104;
  localparam logic [ROW_W-1:0] ROW4_RST = 25'd27025109;

  // One digraph for the back end; the flags belong to its second letter.
  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    run_last;
    logic    message_end;
  } job_t;

  typedef struct packed {
    pos_t row;
    pos_t col;
  } loc_t;

  function automatic letter_t cell_at(input square_t sq, input pos_t r, input pos_t c);
    cell_at = sq[r][c*LETTER_W +: LETTER_W];
  endfunction

  // First match in row-major order wins; a missing letter sits at row 0, column 0.
  function automatic loc_t locate(input square_t sq, input letter_t letter);
    loc_t res;
    res = '0;
    for (int r = GRID_SIDE - 1; r >= 0; r--) begin
      for (int c = GRID_SIDE - 1; c >= 0; c--) begin
        if (sq[r][c*LETTER_W +: LETTER_W] == letter) begin
          res.row = POS_W'(r);
          res.col = POS_W'(c);
        end
      end
    end
    locate = res;
  endfunction

  // Moves a row or column index one place forward (encrypt) or back (decrypt), wrapping.
  function automatic pos_t step_pos(input pos_t p, input logic dec);
    logic [POS_W:0] s;
    s = {1'b0, p} + (dec ? (POS_W+1)'(GRID_SIDE - 1) : (POS_W+1)'(1));
    if (s >= (POS_W+1)'(GRID_SIDE)) begin
      s = s - (POS_W+1)'(GRID_SIDE);
    end
    step_pos = s[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/pf_if.sv @@
// Channel interfaces of the Playfair block: letter input, letter output and configuration writes.
`default_nettype none

interface pf_in_if;
  logic              valid;
  logic              ready;
  pf_pkg::letter_t   in_letter;
  logic              message_last;
  modport source (output valid, output in_letter, output message_last, input ready);
  modport sink   (input valid, input in_letter, input message_last, output ready);
endinterface

interface pf_out_if;
  logic              valid;
  logic              ready;
  pf_pkg::letter_t   out_letter;
  logic              run_last;
  logic              message_end;
  modport source (output valid, output out_letter, output run_last, output message_end,
                  input ready);
  modport sink   (input valid, input out_letter, input run_last, input message_end,
                  output ready);
endinterface

interface pf_cfg_if;
  logic                      valid;
  logic                      ready;
  pf_pkg::cfg_idx_t          index;
  logic [pf_pkg::ROW_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/pf_front.sv @@
// Front end: J folding, letter pairing, filler and padding insertion into digraph jobs.
`default_nettype none

module pf_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pf_pkg::letter_t in_letter,
  input  wire logic            message_last,
  input  wire logic            decrypt,
  input  wire logic            q_full,
  output logic                 push,
  output pf_pkg::job_t         push_job
);

  pf_pkg::letter_t held_letter_r, held_letter_nxt;
  logic            held_valid_r, held_valid_nxt;
  logic            extra_valid_r, extra_valid_nxt;
  pf_pkg::job_t    extra_job_r, extra_job_nxt;
  pf_pkg::letter_t letter;
  pf_pkg::letter_t filler;
  logic            accept;

  assign in_ready = !extra_valid_r && !q_full;
  assign accept   = in_valid && in_ready;
  assign letter   = (in_letter == pf_pkg::CODE_J) ? pf_pkg::CODE_I : in_letter;
  assign filler   = (held_letter_r == pf_pkg::CODE_X) ? pf_pkg::CODE_Q : pf_pkg::CODE_X;

  always_comb begin
    held_letter_nxt = held_letter_r;
    held_valid_nxt  = held_valid_r;
    extra_valid_nxt = extra_valid_r;
    extra_job_nxt   = extra_job_r;
    push            = 1'b0;
    push_job        = '0;
    if (extra_valid_r) begin
      if (!q_full) begin
        push            = 1'b1;
        push_job        = extra_job_r;
        extra_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!held_valid_r) begin
        if (message_last) begin
          push     = 1'b1;
          push_job = '{first: letter, second: pf_pkg::CODE_Z, run_last: 1'b1,
                       message_end: 1'b1};
        end else begin
          held_letter_nxt = letter;
          held_valid_nxt  = 1'b1;
        end
      end else if (!decrypt && (letter == held_letter_r)) begin
        // Doubled letter: split it with a filler and keep the second one pending.
        push     = 1'b1;
        push_job = '{first: held_letter_r, second: filler, run_last: !message_last,
                     message_end: 1'b0};
        if (message_last) begin
          extra_valid_nxt = 1'b1;
          extra_job_nxt   = '{first: letter, second: pf_pkg::CODE_Z, run_last: 1'b1,
                              message_end: 1'b1};
          held_valid_nxt  = 1'b0;
          held_letter_nxt = '0;
        end else begin
          held_letter_nxt = letter;
        end
      end else begin
        push            = 1'b1;
        push_job        = '{first: held_letter_r, second: letter, run_last: 1'b1,
                            message_end: message_last};
        held_valid_nxt  = 1'b0;
        held_letter_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_letter_r <= '0;
      held_valid_r  <= 1'b0;
      extra_valid_r <= 1'b0;
    end else begin
      held_letter_r <= held_letter_nxt;
      held_valid_r  <= held_valid_nxt;
      extra_valid_r <= extra_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    extra_job_r <= extra_job_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/pf_queue.sv @@
// Small job queue between the front and back ends.
`default_nettype none

module pf_queue #(
  parameter int DEPTH = pf_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire pf_pkg::job_t push_job,
  output logic              full,
  input  wire logic         pop,
  output logic              not_empty,
  output pf_pkg::job_t      head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pf_pkg::job_t     store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = store_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pf_back.sv @@
// Back end: key-square lookup of one digraph and delivery of its two letters.
`default_nettype none

module pf_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_valid,
  input  wire pf_pkg::job_t    job,
  output logic                 job_pop,
  input  wire pf_pkg::square_t square,
  input  wire logic            decrypt,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output pf_pkg::letter_t      out_letter,
  output logic                 run_last,
  output logic                 message_end
);

  pf_pkg::loc_t    loc_a, loc_b;
  pf_pkg::letter_t letter_a, letter_b;
  logic            out_free, load_second;

  logic            out_valid_r, out_valid_nxt;
  pf_pkg::letter_t out_letter_r;
  logic            run_last_r, message_end_r;
  logic            second_valid_r, second_valid_nxt;
  pf_pkg::letter_t second_letter_r;
  logic            second_run_last_r, second_msg_end_r;

  assign loc_a = pf_pkg::locate(square, job.first);
  assign loc_b = pf_pkg::locate(square, job.second);

  always_comb begin
    if (loc_a.row == loc_b.row) begin
      letter_a = pf_pkg::cell_at(square, loc_a.row, pf_pkg::step_pos(loc_a.col, decrypt));
      letter_b = pf_pkg::cell_at(square, loc_b.row, pf_pkg::step_pos(loc_b.col, decrypt));
    end else if (loc_a.col == loc_b.col) begin
      letter_a = pf_pkg::cell_at(square, pf_pkg::step_pos(loc_a.row, decrypt), loc_a.col);
      letter_b = pf_pkg::cell_at(square, pf_pkg::step_pos(loc_b.row, decrypt), loc_b.col);
    end else begin
      letter_a = pf_pkg::cell_at(square, loc_a.row, loc_b.col);
      letter_b = pf_pkg::cell_at(square, loc_b.row, loc_a.col);
    end
  end

  assign out_free    = !out_valid_r || out_ready;
  assign load_second = second_valid_r && out_free;
  assign job_pop     = job_valid && !second_valid_r && out_free;

  always_comb begin
    out_valid_nxt    = out_valid_r;
    second_valid_nxt = second_valid_r;
    if (load_second) begin
      out_valid_nxt    = 1'b1;
      second_valid_nxt = 1'b0;
    end else if (job_pop) begin
      out_valid_nxt    = 1'b1;
      second_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      second_valid_r <= 1'b0;
    end else begin
      out_valid_r    <= out_valid_nxt;
      second_valid_r <= second_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_second) begin
      out_letter_r  <= second_letter_r;
      run_last_r    <= second_run_last_r;
      message_end_r <= second_msg_end_r;
    end else if (job_pop) begin
      out_letter_r      <= letter_a;
      run_last_r        <= 1'b0;
      message_end_r     <= 1'b0;
      second_letter_r   <= letter_b;
      second_run_last_r <= job.run_last;
      second_msg_end_r  <= job.message_end;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_letter  = out_letter_r;
  assign run_last    = run_last_r;
  assign message_end = message_end_r;

endmodule

`default_nettype wire

@@ rtl/playfair_digraph_cipher.sv @@
// Top level of the streaming Playfair digraph cipher with its configuration registers.
`default_nettype none

// Playfair cipher over a 5x5 key square that software loads as five row registers
// (indexes 0 to 4, column 0 in the low five bits) plus a mode register (index 5, bit 0
// set for decryption). Letters arrive one per input beat as codes A=0 to Z=25; J is
// folded onto I and the stream is paired into digraphs. In encryption a doubled pair is
// split with the filler X (Q after an X), and a letter left over at the end of a message
// is padded with Z. Every digraph gives two result beats; run_last marks the last beat
// caused by an input beat and message_end the last beat of a message. The front end
// takes one letter per cycle while its job queue has room; after a doubled letter on
// the last beat of a message it waits until the padded job is queued. The back end
// looks up one digraph at a time and sends its letters one per cycle through the output
// register while the output is ready, taking a new digraph once the second letter is
// loaded, so ordinary text where every second letter completes a digraph runs at about
// one input letter per cycle averaged over a pair. Configuration beats are accepted in
// every cycle and must only be sent while the block holds no unfinished letters.
module playfair_digraph_cipher #(
  parameter int QUEUE_DEPTH = pf_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pf_in_if.sink     in_ch,
  pf_out_if.source  out_ch,
  pf_cfg_if.sink    cfg_ch
);

  pf_pkg::square_t square_r;
  logic            decrypt_r;

  logic            q_full, q_not_empty, q_push, q_pop;
  pf_pkg::job_t    q_push_job, q_head_job;

  // The configuration port never stalls; writes beyond the register list are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_r[0] <= pf_pkg::ROW0_RST;
      square_r[1] <= pf_pkg::ROW1_RST;
      square_r[2] <= pf_pkg::ROW2_RST;
      square_r[3] <= pf_pkg::ROW3_RST;
      square_r[4] <= pf_pkg::ROW4_RST;
      decrypt_r   <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pf_pkg::CFG_ROW0: square_r[0] <= cfg_ch.data;
        pf_pkg::CFG_ROW1: square_r[1] <= cfg_ch.data;
        pf_pkg::CFG_ROW2: square_r[2] <= cfg_ch.data;
        pf_pkg::CFG_ROW3: square_r[3] <= cfg_ch.data;
        pf_pkg::CFG_ROW4: square_r[4] <= cfg_ch.data;
        pf_pkg::CFG_MODE: decrypt_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // The front end pairs letters and turns each completed pair into a job.
  pf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_letter    (in_ch.in_letter),
    .message_last (in_ch.message_last),
    .decrypt      (decrypt_r),
    .q_full       (q_full),
    .push         (q_push),
    .push_job     (q_push_job)
  );

  // The queue lets the front end keep taking letters while the back end drains.
  pf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (q_head_job)
  );

  // The back end enciphers or deciphers a job and sends its two letters in successive beats.
  pf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (q_not_empty),
    .job         (q_head_job),
    .job_pop     (q_pop),
    .square      (square_r),
    .decrypt     (decrypt_r),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_letter  (out_ch.out_letter),
    .run_last    (out_ch.run_last),
    .message_end (out_ch.message_end)
  );

endmodule

`default_nettype wire

@@ rtl/pf_checker.sv @@
// Port-level checker for the Playfair block and its bind to the top level.
`default_nettype none

module pf_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire pf_pkg::letter_t out_letter,
  input wire logic            run_last,
  input wire logic            message_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_letter) && $stable(run_last)
      && $stable(message_end))
    else $error("result beat changed while stalled");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && message_end |-> run_last)
    else $error("message end without run end");

  a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("second letter of a digraph not presented at once");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind playfair_digraph_cipher pf_checker u_pf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_letter  (out_ch.out_letter),
  .run_last    (out_ch.run_last),
  .message_end (out_ch.message_end)
);

`default_nettype wire
